>>> design/ilvc_pkg.sv
// Shared types and constants for the index list vertex compaction block.
package ilvc_pkg;

   localparam int GEN_W    = 8;
   localparam int NUM_W    = 16;
   localparam int SRC_W    = 32;
   localparam int VCOUNT_W = 19;
   localparam int STATUS_W = 2;
   localparam int CSR_ADDR_W = 2;

   localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);
   localparam logic [GEN_W-1:0] GEN_LAST  = {GEN_W{1'b1}};

   // Byte address of the vertex_count register.
   localparam logic [CSR_ADDR_W-1:0] ADDR_VERTEX_COUNT = CSR_ADDR_W'(0);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_RANGE    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // latch the incoming item and open a list if marked first
      logic clear;    // write one stale entry of the clearing pass
      logic lookup;   // read the remap entry of the held item
      logic update;   // decide, write back and load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic wrap;        // incoming first item wraps the generation tag
      logic clear_last;  // clearing pass is at its final entry
      logic out_free;    // result register can take a new result
   } sts_type;

endpackage

>>> design/ilvc_ctrl.sv
// Controller state machine sequencing clearing, lookup and update.
module ilvc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  ilvc_pkg::sts_type sts,
   output ilvc_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_LOOKUP = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      pending_ff, pending_in;

   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               pending_in = 1'b0;
               state_in   = pending_ff ? ST_LOOKUP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (sts.wrap) begin
                  pending_in = 1'b1;
                  state_in   = ST_CLEAR;
               end else begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (sts.out_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in   = ST_CLEAR;
            pending_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
   end

endmodule

>>> design/ilvc_dp.sv
// Datapath: remap memory, list state, decision logic and result register.
module ilvc_dp #(
   parameter int SOURCE_DEPTH = 262144,
   parameter int MAX_COMPACT  = 65535
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ilvc_pkg::cmd_type               cmd,
   output ilvc_pkg::sts_type               sts,
   input  logic [ilvc_pkg::SRC_W-1:0]      src_index,
   input  logic                            src_first,
   input  logic [ilvc_pkg::VCOUNT_W-1:0]   vertex_count,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ilvc_pkg::NUM_W-1:0]      rsp_compact_index,
   output logic                            rsp_is_new,
   output logic [ilvc_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int ADDR_W  = $clog2(SOURCE_DEPTH);
   localparam int CNT_W   = $clog2(MAX_COMPACT + 1);
   localparam int ENTRY_W = ilvc_pkg::GEN_W + ilvc_pkg::NUM_W;
   localparam logic [ADDR_W-1:0] CLEAR_END = ADDR_W'(SOURCE_DEPTH - 1);

   logic [ENTRY_W-1:0] mem [SOURCE_DEPTH];
   logic [ENTRY_W-1:0] rd_ff;

   logic [ilvc_pkg::SRC_W-1:0]    src_ff;
   logic [ilvc_pkg::GEN_W-1:0]    gen_ff, gen_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   ilvc_pkg::status_type          sticky_ff, sticky_in;
   logic [ADDR_W-1:0]             clr_ff, clr_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ilvc_pkg::NUM_W-1:0]    rsp_num_ff, rsp_num_in;
   logic                          rsp_new_ff, rsp_new_in;
   ilvc_pkg::status_type          rsp_status_ff, rsp_status_in;

   logic                          we;
   logic [ADDR_W-1:0]             waddr;
   logic [ENTRY_W-1:0]            wdata;

   logic                          in_range;
   logic                          hit;
   logic [ilvc_pkg::GEN_W-1:0]    rd_gen;
   logic [ilvc_pkg::NUM_W-1:0]    rd_num;

   assign rd_gen   = rd_ff[ENTRY_W-1 -: ilvc_pkg::GEN_W];
   assign rd_num   = rd_ff[ilvc_pkg::NUM_W-1:0];
   assign hit      = (rd_gen == gen_ff);
   assign in_range = (src_ff < ilvc_pkg::SRC_W'(vertex_count)) &&
                     (src_ff < ilvc_pkg::SRC_W'(SOURCE_DEPTH));

   assign sts.wrap       = src_first && (gen_ff == ilvc_pkg::GEN_LAST);
   assign sts.clear_last = (clr_ff == CLEAR_END);
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      gen_in        = gen_ff;
      count_in      = count_ff;
      sticky_in     = sticky_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_num_in    = rsp_num_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_status_in = rsp_status_ff;
      we            = 1'b0;
      waddr         = src_ff[ADDR_W-1:0];
      wdata         = {gen_ff, ilvc_pkg::NUM_W'(count_ff)};

      if (cmd.clear) begin
         we     = 1'b1;
         waddr  = clr_ff;
         wdata  = '0;
         clr_in = sts.clear_last ? '0 : clr_ff + ADDR_W'(1);
      end

      if (cmd.accept && src_first) begin
         gen_in    = sts.wrap ? ilvc_pkg::GEN_FIRST : gen_ff + ilvc_pkg::GEN_W'(1);
         count_in  = '0;
         sticky_in = ilvc_pkg::STATUS_OK;
      end

      if (cmd.update) begin
         rsp_valid_in  = 1'b1;
         rsp_num_in    = '0;
         rsp_new_in    = 1'b0;
         rsp_status_in = sticky_ff;
         if (sticky_ff == ilvc_pkg::STATUS_OK) begin
            if (!in_range) begin
               sticky_in     = ilvc_pkg::STATUS_RANGE;
               rsp_status_in = ilvc_pkg::STATUS_RANGE;
            end else if (hit) begin
               rsp_num_in = rd_num;
            end else if (count_ff >= CNT_W'(MAX_COMPACT)) begin
               sticky_in     = ilvc_pkg::STATUS_OVERFLOW;
               rsp_status_in = ilvc_pkg::STATUS_OVERFLOW;
            end else begin
               we         = 1'b1;
               rsp_num_in = ilvc_pkg::NUM_W'(count_ff);
               rsp_new_in = 1'b1;
               count_in   = count_ff + CNT_W'(1);
            end
         end
      end
   end

   // Remap memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.lookup) begin
         rd_ff <= mem[src_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         src_ff <= src_index;
      end
      rsp_num_ff    <= rsp_num_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff       <= ilvc_pkg::GEN_FIRST;
         count_ff     <= '0;
         sticky_ff    <= ilvc_pkg::STATUS_OK;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gen_ff       <= gen_in;
         count_ff     <= count_in;
         sticky_ff    <= sticky_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_compact_index = rsp_num_ff;
   assign rsp_is_new        = rsp_new_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

>>> design/index_list_vertex_compaction.sv
// Top level of the index list vertex compaction block with its register port.
//
//   Channel  Direction  Handshake             Contents
//   req      in         req_tvalid/tready     tdata: source_index; tuser: first
//   rsp      out        rsp_tvalid/tready     tdata: compact_index; tuser: is_new, status
//   csr      in         APB, pready tied high register 0 at byte address 0: vertex_count
//
// Each item passes in order through the transfer, the registered remap memory read, and an
// update that decides, writes the entry back and loads the result register.
// After reset a clearing pass over all SOURCE_DEPTH entries zeroes the remap tags before the
// first transfer; the same pass delays a first item whose list tag would wrap.
// A finished result may wait on rsp_tready while the next item is taken; that item
// then holds in its update cycle until the result register frees.
module index_list_vertex_compaction #(
   parameter int SOURCE_DEPTH = 262144,
   parameter int MAX_COMPACT  = 65535
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] source_index
   input  logic        req_tuser,   // [0] first
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] compact_index
   output logic [2:0]  rsp_tuser,   // [0] is_new, [2:1] status
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   ilvc_pkg::cmd_type                     cmd;
   ilvc_pkg::sts_type                     sts;
   logic [ilvc_pkg::VCOUNT_W-1:0]         vcount_ff, vcount_in;
   logic [ilvc_pkg::NUM_W-1:0]            compact_index;
   logic                                  is_new;
   logic [ilvc_pkg::STATUS_W-1:0]         status;
   logic                                  csr_write;

   // The register port never stalls; a write completes in its access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      vcount_in = vcount_ff;
      if (csr_write && (csr_paddr == ilvc_pkg::ADDR_VERTEX_COUNT)) begin
         vcount_in = csr_pwdata[ilvc_pkg::VCOUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
      end else begin
         vcount_ff <= vcount_in;
      end
   end

   // Reads of unmapped addresses return zero.
   assign csr_prdata = (csr_paddr == ilvc_pkg::ADDR_VERTEX_COUNT) ? 32'(vcount_ff) : '0;

   ilvc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ilvc_dp #(
      .SOURCE_DEPTH (SOURCE_DEPTH),
      .MAX_COMPACT  (MAX_COMPACT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .src_index         (req_tdata),
      .src_first         (req_tuser),
      .vertex_count      (vcount_ff),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_compact_index (compact_index),
      .rsp_is_new        (is_new),
      .rsp_status        (status)
   );

   assign rsp_tdata = compact_index;
   assign rsp_tuser = {status, is_new};

endmodule

>>> dv/tb.sv
// Self-checking testbench for the index list vertex compaction block.
`timescale 1ns / 1ps

module tb;

   // Block configuration under test and the run's bounds.
   localparam int SOURCE_DEPTH = 262144;
   localparam int MAX_COMPACT  = 65535;
   localparam int TAIL_CYCLES = 20;
   // Two clearing passes over SOURCE_DEPTH entries (reset and one tag wrap), about
   // 1600 items, plus generous room for random stalls.
   localparam int CYCLE_LIMIT = 4000000;

   // One compaction result as the block reports it.
   typedef struct packed {
      bit [ilvc_pkg::NUM_W-1:0] number;
      bit                       fresh;
      ilvc_pkg::status_type     status;
   } vertex_result_type;

   // One row of the directed table. When known is set the result column is
   // taken as the expectation; otherwise the predictor supplies it.
   typedef struct packed {
      bit [ilvc_pkg::SRC_W-1:0] source;
      bit                       opens_list;
      bit                       known;
      vertex_result_type        result;
   } probe_type;

   logic             clock;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [31:0]      req_tdata   = '0;   // [31:0] source_index
   logic             req_tuser   = 1'b0; // [0] first
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [15:0]      rsp_tdata;          // [15:0] compact_index
   logic [2:0]       rsp_tuser;          // [0] is_new, [2:1] status
   logic             csr_psel    = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite  = 1'b0;
   logic [1:0]       csr_paddr   = '0;
   logic [31:0]      csr_pwdata  = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   index_list_vertex_compaction #(
      .SOURCE_DEPTH(SOURCE_DEPTH),
      .MAX_COMPACT (MAX_COMPACT)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Shadow of the block's state, kept by the predictor below. The remap
   // arrays are two-state, so entries start at zero just as the tags do.
   bit [ilvc_pkg::NUM_W-1:0]    remap_num [SOURCE_DEPTH];
   bit [ilvc_pkg::GEN_W-1:0]    remap_tag [SOURCE_DEPTH];
   bit [ilvc_pkg::GEN_W-1:0]    open_tag         = ilvc_pkg::GEN_FIRST;
   int unsigned                 seen_count       = 0;
   ilvc_pkg::status_type        list_status      = ilvc_pkg::STATUS_OK;
   bit [ilvc_pkg::VCOUNT_W-1:0] vertex_count_reg = '0;

   // Results owed by the block, oldest first.
   vertex_result_type compactions_due [$];
   vertex_result_type oldest_due;

   int          send_idle_pct = 19;
   int          recv_idle_pct = 85;
   int          mismatch_count = 0;
   int unsigned cycle_count = 0;

   // Directed table, run from the list opened by reset with vertex_count at
   // the memory depth. It covers items before any first, both ends of the
   // index range, the first out-of-range index, an error on a first item,
   // the sticky error holding until the next list, and a list reopening an
   // index that the previous list had already numbered.
   localparam vertex_result_type RANGE_ERROR =
      '{number: '0, fresh: 1'b0, status: ilvc_pkg::STATUS_RANGE};
   probe_type directed_probes [16] = '{
      '{32'd5,          1'b0, 1'b1, '{16'd0, 1'b1, ilvc_pkg::STATUS_OK}},
      '{32'd262143,     1'b0, 1'b1, '{16'd1, 1'b1, ilvc_pkg::STATUS_OK}},
      '{32'd5,          1'b0, 1'b1, '{16'd0, 1'b0, ilvc_pkg::STATUS_OK}},
      '{32'd0,          1'b0, 1'b1, '{16'd2, 1'b1, ilvc_pkg::STATUS_OK}},
      '{32'd262144,     1'b0, 1'b1, RANGE_ERROR},
      '{32'd5,          1'b0, 1'b1, RANGE_ERROR},
      '{32'hFFFF_FFFF,  1'b1, 1'b1, RANGE_ERROR},
      '{32'd0,          1'b1, 1'b1, '{16'd0, 1'b1, ilvc_pkg::STATUS_OK}},
      '{32'd262143,     1'b0, 1'b1, '{16'd1, 1'b1, ilvc_pkg::STATUS_OK}},
      '{32'd0,          1'b0, 1'b1, '{16'd0, 1'b0, ilvc_pkg::STATUS_OK}},
      '{32'h8000_0000,  1'b0, 1'b1, RANGE_ERROR},
      '{32'd1,          1'b1, 1'b1, '{16'd0, 1'b1, ilvc_pkg::STATUS_OK}},
      '{32'd1,          1'b1, 1'b1, '{16'd0, 1'b1, ilvc_pkg::STATUS_OK}},
      '{32'd1,          1'b0, 1'b1, '{16'd0, 1'b0, ilvc_pkg::STATUS_OK}},
      '{32'd262143,     1'b0, 1'b0, '{16'd0, 1'b0, ilvc_pkg::STATUS_OK}},
      '{32'h7FFF_FFFF,  1'b1, 1'b1, RANGE_ERROR}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Opening a list bumps the tag. Zero is never a live tag, so when the bump
   // would wrap, every stored tag is cleared and the tag starts over at one.
   function automatic void open_vertex_list();
      if (open_tag == ilvc_pkg::GEN_LAST) begin
         foreach (remap_tag[i]) remap_tag[i] = '0;
         open_tag = ilvc_pkg::GEN_FIRST;
      end else begin
         open_tag = open_tag + 1'b1;
      end
      seen_count  = 0;
      list_status = ilvc_pkg::STATUS_OK;
   endfunction

   // Compaction of one source index, updating the shadow state.
   function automatic vertex_result_type compact_vertex(
         input bit [ilvc_pkg::SRC_W-1:0] source, input bit opens_list);
      vertex_result_type outcome;
      int unsigned       limit;
      outcome = '{number: '0, fresh: 1'b0, status: ilvc_pkg::STATUS_OK};
      if (opens_list) open_vertex_list();
      limit = (vertex_count_reg > SOURCE_DEPTH) ? SOURCE_DEPTH : vertex_count_reg;
      if (list_status == ilvc_pkg::STATUS_OK) begin
         if (source >= limit) begin
            list_status = ilvc_pkg::STATUS_RANGE;
         end else if (remap_tag[source] == open_tag) begin
            outcome.number = remap_num[source];
         end else if (seen_count >= MAX_COMPACT) begin
            // The vertex that would need number MAX_COMPACT is not recorded.
            list_status = ilvc_pkg::STATUS_OVERFLOW;
         end else begin
            outcome.number    = seen_count[ilvc_pkg::NUM_W-1:0];
            outcome.fresh     = 1'b1;
            remap_num[source] = seen_count[ilvc_pkg::NUM_W-1:0];
            remap_tag[source] = open_tag;
            seen_count++;
         end
      end
      // Once an error is up, every result of the list carries only the status.
      if (list_status != ilvc_pkg::STATUS_OK) begin
         outcome.number = '0;
         outcome.fresh  = 1'b0;
      end
      outcome.status = list_status;
      return outcome;
   endfunction

   // Random source index: mostly a small pool so lists revisit their vertices,
   // some from the top of the memory, and a few that straddle the configured
   // limit or the memory depth, or are any 32-bit value at all.
   function automatic bit [ilvc_pkg::SRC_W-1:0] pick_source(input int unsigned pool_span,
                                                            input bit use_top);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) return $urandom();
      if (roll < 5) return SOURCE_DEPTH - 2 + $urandom_range(0, 3);
      if (roll < 9) return vertex_count_reg + $urandom_range(0, 1) - 1;
      if (use_top && roll < 55) return SOURCE_DEPTH - 32 + $urandom_range(0, 31);
      return $urandom_range(0, pool_span - 1);
   endfunction

   // Offers one item, with a random gap before it, and records the result it
   // owes once the transfer happens. The valid is left high between
   // back-to-back items.
   task automatic send_vertex(input bit [ilvc_pkg::SRC_W-1:0] source,
                              input bit opens_list, input bit known,
                              input vertex_result_type known_result);
      vertex_result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= source;
      req_tuser  <= opens_list;
      do @(posedge clock); while (!req_tready);
      predicted = compact_vertex(source, opens_list);
      compactions_due.insert(compactions_due.size(), known ? known_result : predicted);
   endtask

   // Holds the sender back until every owed result has come out. Each item
   // owes exactly one result, so the block is then idle.
   task automatic settle_results();
      req_tvalid <= 1'b0;
      while (compactions_due.size() != 0) @(posedge clock);
   endtask

   // Writes vertex_count, then reads it back through the same port.
   task automatic program_vertex_count(input logic [31:0] value);
      logic [31:0] readback;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ilvc_pkg::ADDR_VERTEX_COUNT;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      vertex_count_reg = value[ilvc_pkg::VCOUNT_W-1:0];
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== 32'(vertex_count_reg)) begin
         $display("%0t: vertex_count readback expected %0h actual %0h",
                  $time, 32'(vertex_count_reg), readback);
         mismatch_count++;
      end
   endtask

   // Lists of one to nine items; the first item of each opens the list.
   task automatic run_random_lists(input int lists, input int unsigned pool_span,
                                   input bit use_top);
      int length;
      for (int l = 0; l < lists; l++) begin
         length = $urandom_range(1, 9);
         for (int k = 0; k < length; k++)
            send_vertex(pick_source(pool_span, use_top), k == 0, 1'b0, '0);
      end
   endtask

   // Receiver: stalls at random and checks each result transfer against the
   // oldest owed result.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (compactions_due.size() == 0) begin
            $display("%0t: result expected none actual %0d/%0b/%0d", $time,
                     rsp_tdata, rsp_tuser[0], rsp_tuser[2:1]);
            mismatch_count++;
         end else begin
            oldest_due = compactions_due.pop_front();
            if (rsp_tdata !== oldest_due.number || rsp_tuser[0] !== oldest_due.fresh ||
                rsp_tuser[2:1] !== oldest_due.status) begin
               $display("%0t: compact/new/status expected %0d/%0b/%0d actual %0d/%0b/%0d",
                        $time, oldest_due.number, oldest_due.fresh, oldest_due.status,
                        rsp_tdata, rsp_tuser[0], rsp_tuser[2:1]);
               mismatch_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog. The reset clearing pass alone covers all SOURCE_DEPTH entries.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table, with the sender idling lightly and the receiver often.
      program_vertex_count(SOURCE_DEPTH);
      foreach (directed_probes[i])
         send_vertex(directed_probes[i].source, directed_probes[i].opens_list,
                     directed_probes[i].known, directed_probes[i].result);

      // A small source range, so indices recur within and across lists.
      settle_results();
      program_vertex_count(48);
      run_random_lists(120, 64, 1'b0);

      // All ones written: the count exceeds the memory depth and is clamped.
      // Here the sender idles often and the receiver lightly.
      settle_results();
      send_idle_pct = 85;
      recv_idle_pct = 19;
      program_vertex_count(32'hFFFF_FFFF);
      run_random_lists(120, 32, 1'b1);

      // From here on neither side idles. A zero count makes every index an
      // error; the tag wrap and its clearing pass fall in these lists.
      settle_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_vertex_count(0);
      run_random_lists(10, 4, 1'b0);

      // After the wrap, tags of lists from before it come round again, so
      // entries that were not cleared would show up as false hits.
      settle_results();
      program_vertex_count(40);
      run_random_lists(60, 48, 1'b0);

      settle_results();
      program_vertex_count(1);
      run_random_lists(10, 2, 1'b0);

      settle_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
